// ----- design/hwba_pkg.sv -----
// ----------------------------------------------------------------------------
// Heartbeat watchdog package
// Shared constants, op codes, LED codes, register offsets and sequencer states.
// ----------------------------------------------------------------------------
package hwba_pkg;

    localparam int CHANNELS = 16;
    localparam int SLOT_W   = 4;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_REGISTER   = 3'd1;
    localparam logic [2:0] OP_UNREGISTER = 3'd2;
    localparam logic [2:0] OP_HEARTBEAT  = 3'd3;
    localparam logic [2:0] OP_ENABLE     = 3'd4;
    localparam logic [2:0] OP_DISABLE    = 3'd5;

    localparam logic [1:0] LED_DARK = 2'd0;
    localparam logic [1:0] LED_RED  = 2'd1;
    localparam logic [1:0] LED_OK   = 2'd2;

    localparam logic [2:0] REG_PERIOD  = 3'd0;
    localparam logic [2:0] REG_ON_TIME = 3'd1;
    localparam logic [2:0] REG_CYCLE   = 3'd2;
    localparam logic [2:0] REG_BEEP_EN = 3'd3;
    localparam logic [2:0] REG_TONE    = 3'd4;
    localparam logic [2:0] REG_LEVEL   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PATTERN,
        ST_BLINK,
        ST_DONE
    } state_t;

endpackage

// ----- design/heartbeat_watchdog_blink_alarm.sv -----
// ----------------------------------------------------------------------------
// Heartbeat watchdog with blink-code alarm
// Slot table of device heartbeats scanned per tick by one shared comparator;
// a pattern sequencer drives the LED and beeper from the scan result.
// Non-tick ops pass through ST_DONE, which raises the result.
// Tick ops pass one slot per cycle through the shared elapsed-time
// subtract and compare, then two pattern steps and the output.
// One item at a time; in_ready is low from transfer until the result leaves,
// so a new op is taken only once the previous result has been accepted.
// Reset clears slot valid bits, time base, scan result and pattern state.
// ----------------------------------------------------------------------------
module heartbeat_watchdog_blink_alarm (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [3:0]  slot,
    input  logic [15:0] entry_timeout,
    input  logic [7:0]  entry_beeps,
    input  logic        entry_enable,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        slot_offline,
    output logic [1:0]  led_color,
    output logic        beep_on,
    output logic [15:0] beep_tone_out,
    output logic [15:0] beep_level_out,
    output logic        silent_fault,
    output logic [7:0]  alarm_beeps
);

    localparam int C = hwba_pkg::CHANNELS;

    logic [15:0] period_reg, on_time_reg, cycle_reg, tone_reg, level_reg;
    logic        beep_en_reg;

    logic [C-1:0] valid_reg;
    logic [C-1:0] enabled_reg;
    logic [C-1:0] down_reg;
    logic [31:0]  last_seen_mem [C];
    logic [15:0]  limit_mem [C];
    logic [7:0]   beeps_mem [C];

    hwba_pkg::state_t state_reg, state_next;
    logic [hwba_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [3:0]  slot_reg;
    logic [31:0] now_reg;
    logic        severe_reg, silent_acc_reg;
    logic [7:0]  least_reg;
    logic        silent_reg;
    logic [7:0]  chosen_reg;
    logic [31:0] pstart_reg, cstart_reg;
    logic [7:0]  left_reg;
    logic [1:0]  led_reg;
    logic        beep_reg;
    logic        out_valid_reg;
    logic        offline_reg;

    // shared unit: wrapping subtract and compare
    logic [31:0] sub_a, sub_b, diff;
    logic [31:0] cmp_b;
    logic        gt, lt;
    logic [hwba_pkg::IDX_W-1:0] idx;
    logic        slot_in_range;
    logic [hwba_pkg::IDX_W-1:0] k;

    assign idx           = idx_reg[hwba_pkg::IDX_W-1:0];
    assign slot_in_range = ({28'd0, slot_reg} < 32'(C));
    assign k             = slot_reg[hwba_pkg::IDX_W-1:0];
    assign diff          = sub_a - sub_b;
    assign gt            = diff > cmp_b;
    assign lt            = diff < cmp_b;

    always_comb
    begin
        sub_a = now_reg;
        sub_b = last_seen_mem[idx];
        cmp_b = {16'd0, limit_mem[idx]};
        case (state_reg)
            hwba_pkg::ST_PATTERN:
            begin
                sub_b = pstart_reg;
                cmp_b = {16'd0, period_reg};
            end
            hwba_pkg::ST_BLINK:
            begin
                sub_b = cstart_reg;
                cmp_b = {16'd0, on_time_reg};
            end
            default:
            begin
            end
        endcase
    end

    // blink phase needs a second compare against cycle_reg
    logic lt_cycle;
    assign lt_cycle = diff < {16'd0, cycle_reg};

    assign pready   = 1'b1;
    assign in_ready = (state_reg == hwba_pkg::ST_IDLE) && !out_valid_reg;

    always_comb
    begin
        case (paddr[4:2])
            hwba_pkg::REG_PERIOD:  prdata = {16'd0, period_reg};
            hwba_pkg::REG_ON_TIME: prdata = {16'd0, on_time_reg};
            hwba_pkg::REG_CYCLE:   prdata = {16'd0, cycle_reg};
            hwba_pkg::REG_BEEP_EN: prdata = {31'd0, beep_en_reg};
            hwba_pkg::REG_TONE:    prdata = {16'd0, tone_reg};
            hwba_pkg::REG_LEVEL:   prdata = {16'd0, level_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= 16'd2000;
            on_time_reg <= 16'd100;
            cycle_reg   <= 16'd200;
            beep_en_reg <= 1'b1;
            tone_reg    <= 16'd0;
            level_reg   <= 16'd0;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                hwba_pkg::REG_PERIOD:  period_reg  <= pwdata[15:0];
                hwba_pkg::REG_ON_TIME: on_time_reg <= pwdata[15:0];
                hwba_pkg::REG_CYCLE:   cycle_reg   <= pwdata[15:0];
                hwba_pkg::REG_BEEP_EN: beep_en_reg <= pwdata[0];
                hwba_pkg::REG_TONE:    tone_reg    <= pwdata[15:0];
                hwba_pkg::REG_LEVEL:   level_reg   <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            hwba_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    idx_next   = '0;
                    state_next = (op == hwba_pkg::OP_TICK) ? hwba_pkg::ST_SCAN
                                                           : hwba_pkg::ST_DONE;
                end
            end
            hwba_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == hwba_pkg::CNT_W'(C - 1))
                    state_next = hwba_pkg::ST_PATTERN;
            end
            hwba_pkg::ST_PATTERN: state_next = hwba_pkg::ST_BLINK;
            hwba_pkg::ST_BLINK:   state_next = hwba_pkg::ST_DONE;
            hwba_pkg::ST_DONE:    state_next = hwba_pkg::ST_IDLE;
            default:              state_next = hwba_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hwba_pkg::ST_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            now_reg        <= 32'd0;
            severe_reg     <= 1'b0;
            silent_acc_reg <= 1'b0;
            least_reg      <= 8'd0;
            silent_reg     <= 1'b0;
            chosen_reg     <= 8'd0;
            pstart_reg     <= 32'd0;
            cstart_reg     <= 32'd0;
            left_reg       <= 8'd0;
            led_reg        <= hwba_pkg::LED_DARK;
            beep_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                hwba_pkg::ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        severe_reg     <= 1'b0;
                        silent_acc_reg <= 1'b0;
                        least_reg      <= 8'd0;
                        if (op == hwba_pkg::OP_TICK)
                            now_reg <= now_reg + 32'd1;
                        else if ({28'd0, slot} < 32'(C))
                        begin
                            if (op == hwba_pkg::OP_REGISTER)
                                valid_reg[slot[hwba_pkg::IDX_W-1:0]] <= 1'b1;
                            else if (op == hwba_pkg::OP_UNREGISTER)
                                valid_reg[slot[hwba_pkg::IDX_W-1:0]] <= 1'b0;
                        end
                    end
                end
                hwba_pkg::ST_SCAN:
                begin
                    if (valid_reg[idx] && enabled_reg[idx] && gt)
                    begin
                        if (beeps_mem[idx] != 8'd0)
                        begin
                            severe_reg <= 1'b1;
                            if (least_reg == 8'd0 || beeps_mem[idx] < least_reg)
                                least_reg <= beeps_mem[idx];
                        end
                        else
                            silent_acc_reg <= 1'b1;
                    end
                    if (idx_reg == hwba_pkg::CNT_W'(C - 1))
                    begin
                        // close scan using the last slot's contribution too
                        if (valid_reg[idx] && enabled_reg[idx] && gt
                            && beeps_mem[idx] != 8'd0)
                        begin
                            silent_reg <= 1'b0;
                            chosen_reg <= (least_reg == 8'd0 || beeps_mem[idx] < least_reg)
                                          ? beeps_mem[idx] : least_reg;
                        end
                        else if (severe_reg)
                        begin
                            silent_reg <= 1'b0;
                            chosen_reg <= least_reg;
                        end
                        else
                        begin
                            silent_reg <= silent_acc_reg ||
                                          (valid_reg[idx] && enabled_reg[idx] && gt);
                            chosen_reg <= 8'd0;
                        end
                    end
                end
                hwba_pkg::ST_PATTERN:
                begin
                    if (silent_reg)
                    begin
                        beep_reg   <= 1'b0;
                        led_reg    <= hwba_pkg::LED_RED;
                        left_reg   <= 8'd0;
                        pstart_reg <= now_reg;
                    end
                    else if (gt)
                    begin
                        left_reg   <= chosen_reg;
                        pstart_reg <= now_reg;
                        cstart_reg <= now_reg;
                    end
                end
                hwba_pkg::ST_BLINK:
                begin
                    if (!silent_reg)
                    begin
                        if (left_reg != 8'd0)
                        begin
                            if (lt)
                            begin
                                beep_reg <= beep_en_reg;
                                led_reg  <= hwba_pkg::LED_RED;
                            end
                            else if (lt_cycle)
                            begin
                                beep_reg <= 1'b0;
                                led_reg  <= hwba_pkg::LED_DARK;
                            end
                            else
                            begin
                                left_reg   <= left_reg - 8'd1;
                                cstart_reg <= now_reg;
                            end
                        end
                        else
                        begin
                            beep_reg <= 1'b0;
                            led_reg  <= (chosen_reg != 8'd0) ? hwba_pkg::LED_DARK
                                                             : hwba_pkg::LED_OK;
                        end
                    end
                end
                hwba_pkg::ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot storage and per-slot flags without reset
    always_ff @(posedge clk)
    begin
        case (state_reg)
            hwba_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready && op != hwba_pkg::OP_TICK
                    && {28'd0, slot} < 32'(C))
                begin
                    slot_reg <= slot;
                    if (op == hwba_pkg::OP_REGISTER)
                    begin
                        limit_mem[slot[hwba_pkg::IDX_W-1:0]]     <= entry_timeout;
                        beeps_mem[slot[hwba_pkg::IDX_W-1:0]]     <= entry_beeps;
                        enabled_reg[slot[hwba_pkg::IDX_W-1:0]]   <= entry_enable;
                        down_reg[slot[hwba_pkg::IDX_W-1:0]]      <= 1'b1;
                        last_seen_mem[slot[hwba_pkg::IDX_W-1:0]] <= 32'd0;
                    end
                    else if (valid_reg[slot[hwba_pkg::IDX_W-1:0]])
                    begin
                        if (op == hwba_pkg::OP_HEARTBEAT)
                            last_seen_mem[slot[hwba_pkg::IDX_W-1:0]] <= now_reg;
                        else if (op == hwba_pkg::OP_ENABLE)
                            enabled_reg[slot[hwba_pkg::IDX_W-1:0]] <= 1'b1;
                        else if (op == hwba_pkg::OP_DISABLE)
                            enabled_reg[slot[hwba_pkg::IDX_W-1:0]] <= 1'b0;
                    end
                end
                else if (in_valid && in_ready)
                begin
                    slot_reg <= slot;
                end
            end
            hwba_pkg::ST_SCAN:
            begin
                if (valid_reg[idx] && enabled_reg[idx])
                    down_reg[idx] <= gt;
            end
            hwba_pkg::ST_DONE:
            begin
                offline_reg <= (slot_in_range && valid_reg[k]) ? down_reg[k] : 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign slot_offline   = offline_reg;
    assign led_color      = led_reg;
    assign beep_on        = beep_reg;
    assign beep_tone_out  = beep_reg ? tone_reg : 16'd0;
    assign beep_level_out = beep_reg ? level_reg : 16'd0;
    assign silent_fault   = silent_reg;
    assign alarm_beeps    = chosen_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == hwba_pkg::ST_IDLE))
        else $error("ready outside idle");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hwba_pkg::ST_SCAN) |-> (idx_reg < hwba_pkg::CNT_W'(C)))
        else $error("scan index out of range");
    a_silent_excl: assert property (@(posedge clk) disable iff (!rst_n)
        silent_reg |-> (chosen_reg == 8'd0))
        else $error("silent and severe together");
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hwba_pkg::ST_DONE) |=> out_valid_reg)
        else $error("result not raised");

endmodule
